FILE: src/cdq_pkg.sv
// Shared constants, codes and types for the circular deque.
package cdq_pkg;

  localparam int DEPTH      = 128;
  localparam int PTR_BITS   = $clog2(DEPTH);
  localparam int WORD_BITS  = 32;
  localparam int KIND_BITS  = 3;
  localparam int STAT_BITS  = 2;
  localparam int COUNT_BITS = 7;

  localparam logic [KIND_BITS-1:0] K_PUSH_FRONT = 3'd0;
  localparam logic [KIND_BITS-1:0] K_PUSH_REAR  = 3'd1;
  localparam logic [KIND_BITS-1:0] K_POP_FRONT  = 3'd2;
  localparam logic [KIND_BITS-1:0] K_POP_REAR   = 3'd3;
  localparam logic [KIND_BITS-1:0] K_PEEK_FRONT = 3'd4;
  localparam logic [KIND_BITS-1:0] K_PEEK_REAR  = 3'd5;

  localparam logic [STAT_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [PTR_BITS-1:0] addr;
  } cdq_mem_req_t;

  typedef struct packed {
    logic [STAT_BITS-1:0]  status;
    logic [COUNT_BITS-1:0] count;
    logic                  is_empty;
    logic                  has_data;
  } cdq_result_t;

endpackage

FILE: src/circular_deque.sv
// Top level of the circular deque: request decode, slot memory and result register.
// Each transaction's result is registered and appears in the cycle after it is accepted.
// A new transaction is accepted every cycle while the result side takes results.
// The single result register stalls the request side only while a result waits.
// Reset clears both pointers, so the deque starts empty; slot contents are not reset.
module circular_deque
  import cdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [KIND_BITS-1:0]  kind,
  input  logic [WORD_BITS-1:0]  payload,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [WORD_BITS-1:0]  read_word,
  output logic [STAT_BITS-1:0]  status,
  output logic [COUNT_BITS-1:0] count,
  output logic                  is_empty
);

  cdq_mem_req_t         req;
  cdq_result_t          res;
  cdq_result_t          res_q;
  logic [WORD_BITS-1:0] rd_data;
  logic                 accept;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  cdq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (kind),
    .req    (req),
    .res    (res)
  );

  cdq_store u_store (
    .clk     (clk),
    .accept  (accept),
    .req     (req),
    .wr_data (payload),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign read_word = res_q.has_data ? rd_data : '0;
  assign status    = res_q.status;
  assign count     = res_q.count;
  assign is_empty  = res_q.is_empty;

  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (count == '0)))
    else $error("Empty flag disagrees with count.");

  a_refused_no_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_DONE) |-> (read_word == '0))
    else $error("Refused or empty transaction returned a word.");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("Accepted transaction produced no result.");

endmodule

FILE: src/cdq_ctrl.sv
// Pointer registers and request decode for the circular deque.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [KIND_BITS-1:0] kind,
  output cdq_mem_req_t         req,
  output cdq_result_t          res
);

  logic [PTR_BITS-1:0] head_ptr;
  logic [PTR_BITS-1:0] tail_ptr;
  logic [PTR_BITS-1:0] head_ptr_next;
  logic [PTR_BITS-1:0] tail_ptr_next;
  logic [PTR_BITS-1:0] head_inc;
  logic [PTR_BITS-1:0] tail_inc;
  logic [PTR_BITS-1:0] held;
  logic                empty;
  logic                full;
  logic                is_push;

  assign head_inc = head_ptr + PTR_BITS'(1);
  assign tail_inc = tail_ptr + PTR_BITS'(1);
  assign empty    = (head_ptr == tail_ptr);
  assign full     = (tail_inc == head_ptr);
  assign is_push  = (kind == K_PUSH_FRONT) || (kind == K_PUSH_REAR);

  always_comb begin
    head_ptr_next = head_ptr;
    tail_ptr_next = tail_ptr;
    req.wr_en     = 1'b0;
    req.rd_en     = 1'b0;
    req.addr      = tail_ptr;
    res.status    = ST_DONE;
    res.has_data  = 1'b0;
    case (kind)
      K_PUSH_FRONT: begin
        req.addr = head_ptr;
        if (full) begin
          res.status = ST_FULL;
        end else begin
          req.wr_en     = 1'b1;
          head_ptr_next = head_ptr - PTR_BITS'(1);
        end
      end
      K_PUSH_REAR: begin
        req.addr = tail_inc;
        if (full) begin
          res.status = ST_FULL;
        end else begin
          req.wr_en     = 1'b1;
          tail_ptr_next = tail_inc;
        end
      end
      K_POP_FRONT: begin
        req.addr = head_inc;
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          req.rd_en     = 1'b1;
          res.has_data  = 1'b1;
          head_ptr_next = head_inc;
        end
      end
      K_POP_REAR: begin
        req.addr = tail_ptr;
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          req.rd_en     = 1'b1;
          res.has_data  = 1'b1;
          tail_ptr_next = tail_ptr - PTR_BITS'(1);
        end
      end
      K_PEEK_FRONT: begin
        req.addr = head_inc;
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          req.rd_en    = 1'b1;
          res.has_data = 1'b1;
        end
      end
      K_PEEK_REAR: begin
        req.addr = tail_ptr;
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          req.rd_en    = 1'b1;
          res.has_data = 1'b1;
        end
      end
      default: begin
        req.addr = tail_ptr;
      end
    endcase
    held         = tail_ptr_next - head_ptr_next;
    res.count    = COUNT_BITS'(held);
    res.is_empty = (held == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
    end else if (accept) begin
      head_ptr <= head_ptr_next;
      tail_ptr <= tail_ptr_next;
    end
  end

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    accept && full && is_push |=> $stable(head_ptr) && $stable(tail_ptr))
    else $error("Refused push moved a pointer.");

  a_no_write_and_read: assert property (@(posedge clk) disable iff (rst)
    !(req.wr_en && req.rd_en))
    else $error("Request both writes and reads the store.");

  a_empty_no_read: assert property (@(posedge clk) disable iff (rst)
    accept && empty |-> !req.rd_en)
    else $error("Read issued on an empty deque.");

endmodule

FILE: src/cdq_store.sv
// Slot memory of the circular deque with one shared port and registered read data.
module cdq_store
  import cdq_pkg::*;
(
  input  logic                 clk,
  input  logic                 accept,
  input  cdq_mem_req_t         req,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (accept && req.wr_en) begin
      mem[req.addr] <= wr_data;
    end
    if (accept && req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

FILE: tb/circular_deque_tb.sv
// Self-checking testbench for circular_deque with a predictor and randomized stalls.
module circular_deque_tb
  import cdq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_BITS-1:0] K_NOP_LO = 3'd6;
  localparam logic [KIND_BITS-1:0] K_NOP_HI = 3'd7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} run_mode_t;
  typedef logic [PTR_BITS-1:0] ptr_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] op;
    logic [WORD_BITS-1:0] word;
  } deque_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]  read_word;
    logic [STAT_BITS-1:0]  status;
    logic [COUNT_BITS-1:0] count;
    logic                  is_empty;
  } deque_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  logic [KIND_BITS-1:0]  kind = '0;
  logic [WORD_BITS-1:0]  payload = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  logic [WORD_BITS-1:0]  read_word;
  logic [STAT_BITS-1:0]  status;
  logic [COUNT_BITS-1:0] count;
  logic                  is_empty;

  deque_req_t req_backlog[$];
  deque_rsp_t expected_rsps[$];

  logic [WORD_BITS-1:0] ring_model[DEPTH];
  ptr_t front_gap = '0;
  ptr_t rear_pos = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  circular_deque u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .kind      (kind),
    .payload   (payload),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .read_word (read_word),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ptr_t ring_next(ptr_t p);
    return ptr_t'((int'(p) + 1) % DEPTH);
  endfunction

  function automatic ptr_t ring_prev(ptr_t p);
    return ptr_t'((int'(p) + DEPTH - 1) % DEPTH);
  endfunction

  function automatic deque_rsp_t deque_apply(logic [KIND_BITS-1:0] op,
                                             logic [WORD_BITS-1:0] word);
    deque_rsp_t res;
    logic       no_elems;
    logic       is_full;
    no_elems = (front_gap == rear_pos);
    is_full  = (ring_next(rear_pos) == front_gap);
    res = '0;
    res.status = ST_DONE;
    case (op)
      K_PUSH_FRONT: begin
        if (is_full) begin
          res.status = ST_FULL;
        end else begin
          ring_model[front_gap] = word;
          front_gap = ring_prev(front_gap);
        end
      end
      K_PUSH_REAR: begin
        if (is_full) begin
          res.status = ST_FULL;
        end else begin
          rear_pos = ring_next(rear_pos);
          ring_model[rear_pos] = word;
        end
      end
      K_POP_FRONT: begin
        if (no_elems) begin
          res.status = ST_EMPTY;
        end else begin
          front_gap = ring_next(front_gap);
          res.read_word = ring_model[front_gap];
        end
      end
      K_POP_REAR: begin
        if (no_elems) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_word = ring_model[rear_pos];
          rear_pos = ring_prev(rear_pos);
        end
      end
      K_PEEK_FRONT: begin
        if (no_elems) res.status = ST_EMPTY;
        else res.read_word = ring_model[ring_next(front_gap)];
      end
      K_PEEK_REAR: begin
        if (no_elems) res.status = ST_EMPTY;
        else res.read_word = ring_model[rear_pos];
      end
      default: begin
      end
    endcase
    res.count = COUNT_BITS'((int'(rear_pos) + DEPTH - int'(front_gap)) % DEPTH);
    res.is_empty = (rear_pos == front_gap);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [WORD_BITS-1:0] got,
                             logic [WORD_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  task automatic add_req(logic [KIND_BITS-1:0] op, logic [WORD_BITS-1:0] word);
    req_backlog.push_back('{op: op, word: word});
  endtask

  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return WORD_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [KIND_BITS-1:0] rand_kind(run_mode_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: return (r < 50) ? K_PUSH_FRONT : K_PUSH_REAR;
      MODE_DRAIN: begin
        if (r < 45) return K_POP_FRONT;
        if (r < 90) return K_POP_REAR;
        return (r < 95) ? K_PEEK_FRONT : K_PEEK_REAR;
      end
      default: begin
        if (r < 25) return K_PUSH_FRONT;
        if (r < 50) return K_PUSH_REAR;
        if (r < 62) return K_POP_FRONT;
        if (r < 74) return K_POP_REAR;
        if (r < 83) return K_PEEK_FRONT;
        if (r < 92) return K_PEEK_REAR;
        return (r < 96) ? K_NOP_LO : K_NOP_HI;
      end
    endcase
  endfunction

  task automatic add_run(run_mode_t mode, int n);
    for (int i = 0; i < n; i++) begin
      add_req(rand_kind(mode), rand_word());
    end
  endtask

  task automatic wait_backlog_empty();
    while (req_backlog.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_proc
    deque_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_backlog.pop_front();
        req_valid <= 1'b1;
        kind      <= nxt.op;
        payload   <= nxt.word;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : watch_proc
    deque_rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(deque_apply(kind, payload));
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_rsps.pop_front();
          check_field("read_word", read_word, want.read_word);
          check_field("status", WORD_BITS'(status), WORD_BITS'(want.status));
          check_field("count", WORD_BITS'(count), WORD_BITS'(want.count));
          check_field("is_empty", WORD_BITS'(is_empty), WORD_BITS'(want.is_empty));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("circular_deque_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Phase with no idling on either side, starting with the corner cases.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_req(K_POP_FRONT, 32'h1234_5678);
    add_req(K_POP_REAR, '1);
    add_req(K_PEEK_FRONT, '0);
    add_req(K_PEEK_REAR, '1);
    add_req(K_NOP_LO, '1);
    add_req(K_NOP_HI, '0);
    add_req(K_PUSH_FRONT, '0);
    add_req(K_POP_REAR, '0);
    add_req(K_PUSH_REAR, '1);
    add_req(K_PUSH_FRONT, '0);
    add_req(K_PUSH_FRONT, 32'h8000_0001);
    add_req(K_PEEK_FRONT, '1);
    add_req(K_PEEK_REAR, '0);
    add_req(K_NOP_HI, '1);
    add_req(K_POP_FRONT, '0);
    add_req(K_POP_REAR, '0);
    add_req(K_POP_FRONT, '0);
    add_req(K_POP_FRONT, '1);
    add_req(K_PUSH_REAR, 32'hA5A5_5A5A);
    add_req(K_PEEK_FRONT, '0);
    add_req(K_POP_REAR, '0);
    add_run(MODE_FILL, DEPTH + 4);
    add_run(MODE_MIX, 40);
    wait_backlog_empty();

    send_idle_pct  = 71;
    recv_stall_pct = 0;
    add_run(MODE_MIX, 40);
    add_run(MODE_DRAIN, DEPTH + 4);
    wait_backlog_empty();

    send_idle_pct  = 0;
    recv_stall_pct = 71;
    add_run(MODE_MIX, 150);
    wait_backlog_empty();

    send_idle_pct  = 20;
    recv_stall_pct = 20;
    add_run(MODE_FILL, DEPTH + 4);
    add_run(MODE_MIX, 20);
    add_run(MODE_DRAIN, 20);
    wait_backlog_empty();

    while (req_valid || expected_rsps.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_rsps.size() != 0) begin
      report_mismatch("expected results left over at the end");
    end

    if (mismatches == 0) begin
      $display("circular_deque_tb: PASS");
    end else begin
      $display("circular_deque_tb: FAIL");
    end
    $finish;
  end

endmodule
